// File: hdl/pwm_input_capture_measure_defines.svh
// Assertion helpers shared by the measurement block.
// Each helper samples on the rising edge of clk and is switched off while rst is high.
`ifndef PWM_INPUT_CAPTURE_MEASURE_DEFINES_SVH
`define PWM_INPUT_CAPTURE_MEASURE_DEFINES_SVH

// Same-cycle implication.
`define PWMCAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PWMCAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pwmcap_pkg.sv
`timescale 1ns / 1ps

package pwmcap_pkg;

  // Field widths.
  localparam int CNT_W     = 16;
  localparam int TICK_W    = 27;
  localparam int FREQ_W    = 26;
  localparam int DUTY_W    = 14;
  localparam int PERIOD_W  = CNT_W + 1;
  // The dividend is wide enough for both the tick rate and the scaled high span.
  localparam int DIVD_W    = 30;
  localparam int DIV_CNT_W = 5;
  localparam int FREQ_PAD  = DIVD_W - TICK_W;

  localparam logic [TICK_W-1:0]    TICK_RATE_RESET = 27'd1000000;
  localparam logic [FREQ_W-1:0]    FREQ_MAX        = {FREQ_W{1'b1}};
  localparam logic [DUTY_W-1:0]    DUTY_SCALE      = 14'd10000;
  localparam logic [DIV_CNT_W-1:0] FREQ_STEPS      = 5'd27;
  localparam logic [DIV_CNT_W-1:0] DUTY_STEPS      = 5'd30;

  // Request to the shared divider.
  typedef struct packed {
    logic                 start;
    logic [DIVD_W-1:0]    dividend;
    logic [PERIOD_W-1:0]  divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_cmd_t;

  // Divider status and result.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_stat_t;

endpackage

// File: hdl/pwmcap_div.sv
`timescale 1ns / 1ps

module pwmcap_div (
  input  logic                  clk,
  input  logic                  rst,
  input  pwmcap_pkg::div_cmd_t  cmd,
  output pwmcap_pkg::div_stat_t stat
);
  import pwmcap_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVD_W-1:0]    dvd;
  logic [PERIOD_W-1:0]  rem;
  logic [PERIOD_W-1:0]  divisor;
  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W:0]    diff;
  logic                 fits;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, dvd[DIVD_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  // Step sequencing; done pulses for one cycle after the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= cmd.steps;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register; quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd     <= cmd.dividend;
      rem     <= '0;
      divisor <= cmd.divisor;
    end else if (busy) begin
      rem <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      dvd <= {dvd[DIVD_W-2:0], fits};
    end
  end

  assign stat.busy     = busy;
  assign stat.done     = done;
  assign stat.quotient = dvd;

endmodule

// File: hdl/pwm_input_capture_measure.sv
// PWM input capture measurement. Each beat on the input carries a 16-bit capture
// timestamp and the channel that latched it; per channel the edges run rise, fall,
// next rise, and that closing rise yields one result beat with the high and low spans
// (modulo 65536), frequency = tick_rate / period (truncated, saturating at 26 bits)
// and duty in hundredths of a percent (truncated). Equal timestamps give a zero span
// and set span_error, which zeroes frequency and duty for that period. An edge that
// does not complete a period, or names a channel beyond NUM_CHANNELS, is taken without
// stalling the input. A completing edge holds off input until its result is loaded:
// S_MUL forms the scaled high span, then a single restoring divider, one quotient bit
// per cycle, runs 27 steps for frequency and 30 steps for duty, each quotient taken
// when the divider signals done, S_DUTY_GO starts the duty division, and S_HOLD loads
// the output register; a span error skips both divisions. A finished result may
// wait on out_ready while further edges are taken; a second completed period then
// waits in the sequencer until the output register frees up. tick_rate resets to
// 1000000 and is written whenever cfg_wr_en is high.
`timescale 1ns / 1ps
`include "pwm_input_capture_measure_defines.svh"

module pwm_input_capture_measure #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pwmcap_pkg::TICK_W-1:0]  cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           channel,
  input  logic [pwmcap_pkg::CNT_W-1:0]   capture_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           result_channel,
  output logic [pwmcap_pkg::CNT_W-1:0]   high_ticks,
  output logic [pwmcap_pkg::CNT_W-1:0]   low_ticks,
  output logic [pwmcap_pkg::FREQ_W-1:0]  frequency,
  output logic [pwmcap_pkg::DUTY_W-1:0]  duty_hundredths,
  output logic                           span_error
);
  import pwmcap_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Per-channel edge phase.
  localparam logic [1:0] PH_RISE = 2'd0;
  localparam logic [1:0] PH_FALL = 2'd1;
  localparam logic [1:0] PH_NEXT = 2'd2;

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL     = 3'd1;
  localparam logic [2:0] S_FREQ    = 3'd2;
  localparam logic [2:0] S_DUTY_GO = 3'd3;
  localparam logic [2:0] S_DUTY    = 3'd4;
  localparam logic [2:0] S_HOLD    = 3'd5;

  logic [TICK_W-1:0]   tick_rate;
  logic [2:0]          state;

  logic [1:0]          phase      [NUM_CHANNELS];
  logic                error_seen [NUM_CHANNELS];
  logic [CNT_W-1:0]    last_stamp [NUM_CHANNELS];
  logic [CNT_W-1:0]    high_span  [NUM_CHANNELS];

  logic                accept;
  logic                ch_ok;
  logic [CH_W-1:0]     ch_idx;
  logic [1:0]          cur_phase;
  logic [CNT_W-1:0]    span;
  logic                same;
  logic                load_out;

  logic                w_ch;
  logic [CNT_W-1:0]    w_high;
  logic [CNT_W-1:0]    w_low;
  logic [PERIOD_W-1:0] w_period;
  logic                w_err;
  logic [DIVD_W-1:0]   prod;
  logic [FREQ_W-1:0]   r_freq;
  logic [DUTY_W-1:0]   r_duty;

  div_cmd_t            div_cmd;
  div_stat_t           div_stat;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= TICK_RATE_RESET;
    end else if (cfg_wr_en) begin
      tick_rate <= cfg_wr_data;
    end
  end

  // Input beat decode against the addressed channel.
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ch_ok    = (32'(channel) < NUM_CHANNELS);
  assign ch_idx   = CH_W'(channel);
  assign cur_phase = phase[ch_idx];
  assign span     = capture_time - last_stamp[ch_idx];
  assign same     = (capture_time == last_stamp[ch_idx]);

  // Phase and sticky error per channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        phase[i]      <= PH_RISE;
        error_seen[i] <= 1'b0;
      end
    end else if (accept && ch_ok) begin
      case (cur_phase)
        PH_FALL: begin
          phase[ch_idx]      <= PH_NEXT;
          error_seen[ch_idx] <= error_seen[ch_idx] | same;
        end
        PH_NEXT: begin
          phase[ch_idx]      <= PH_RISE;
          error_seen[ch_idx] <= error_seen[ch_idx] | same;
        end
        default: begin
          phase[ch_idx]      <= PH_FALL;
          error_seen[ch_idx] <= 1'b0;
        end
      endcase
    end
  end

  // Timestamps and high span per channel.
  always_ff @(posedge clk) begin
    if (accept && ch_ok) begin
      last_stamp[ch_idx] <= capture_time;
      if (cur_phase == PH_FALL) begin
        high_span[ch_idx] <= span;
      end
    end
  end

  // Working copy of a completed period.
  always_ff @(posedge clk) begin
    if (accept && ch_ok && (cur_phase == PH_NEXT)) begin
      w_ch     <= channel;
      w_high   <= high_span[ch_idx];
      w_low    <= span;
      w_period <= PERIOD_W'(high_span[ch_idx]) + PERIOD_W'(span);
      w_err    <= error_seen[ch_idx] | same;
    end
  end

  // Divider requests: frequency first, then duty from the scaled high span.
  always_comb begin
    div_cmd.start    = 1'b0;
    div_cmd.dividend = {tick_rate, {FREQ_PAD{1'b0}}};
    div_cmd.divisor  = w_period;
    div_cmd.steps    = FREQ_STEPS;
    case (state)
      S_MUL: begin
        div_cmd.start = !w_err;
      end
      S_DUTY_GO: begin
        div_cmd.start    = 1'b1;
        div_cmd.dividend = prod;
        div_cmd.steps    = DUTY_STEPS;
      end
      default: begin
        div_cmd.start = 1'b0;
      end
    endcase
  end

  pwmcap_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .stat (div_stat)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && ch_ok && (cur_phase == PH_NEXT)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= w_err ? S_HOLD : S_FREQ;
        end
        S_FREQ: begin
          if (div_stat.done) begin
            state <= S_DUTY_GO;
          end
        end
        S_DUTY_GO: begin
          state <= S_DUTY;
        end
        S_DUTY: begin
          if (div_stat.done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Arithmetic results; an errored period reports zero frequency and duty.
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= DIVD_W'(w_high) * DIVD_W'(DUTY_SCALE);
      if (w_err) begin
        r_freq <= '0;
        r_duty <= '0;
      end
    end
    if ((state == S_FREQ) && div_stat.done) begin
      r_freq <= div_stat.quotient[TICK_W-1] ? FREQ_MAX : div_stat.quotient[FREQ_W-1:0];
    end
    if ((state == S_DUTY) && div_stat.done) begin
      r_duty <= div_stat.quotient[DUTY_W-1:0];
    end
  end

  // Output register.
  assign load_out = (state == S_HOLD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_channel  <= w_ch;
      high_ticks      <= w_high;
      low_ticks       <= w_low;
      frequency       <= r_freq;
      duty_hundredths <= r_duty;
      span_error      <= w_err;
    end
  end

  // Checks.
  `PWMCAP_ASSERT_NOW(a_idle_div_free, in_ready, !div_stat.busy,
    "divider busy while input is open")
  `PWMCAP_ASSERT_NOW(a_done_in_wait, div_stat.done, (state == S_FREQ) || (state == S_DUTY),
    "divider finished outside a wait state")
  `PWMCAP_ASSERT_NEXT(a_period_blocks, accept && ch_ok && (cur_phase == PH_NEXT), !in_ready,
    "completed period did not stall the input")
  `PWMCAP_ASSERT_NOW(a_err_zeroes, out_valid && span_error,
    (frequency == '0) && (duty_hundredths == '0), "errored result has nonzero values")
  `PWMCAP_ASSERT_NOW(a_duty_range, out_valid, duty_hundredths <= DUTY_SCALE,
    "duty above full scale")

endmodule
